@@ design/tlsbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsbs_pkg
// Shared types and constants for the two-level shadow byte store: action
// codes, status codes, default sizes and the command word between the stages.
// ----------------------------------------------------------------------------
package tlsbs_pkg;

  // default sizes
  localparam int POOL_PAGES_DEF         = 16;
  localparam int PAGE_OFFSET_BITS_DEF   = 16;
  localparam int PAGE_TABLE_ENTRIES_DEF = 65536;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // action codes; codes 5 to 7 mean nothing and fall to default arms
  typedef enum logic [2:0] {
    ACT_READ_BYTE  = 3'd0,
    ACT_WRITE_BYTE = 3'd1,
    ACT_SET_BIT    = 3'd2,
    ACT_CLEAR_BIT  = 3'd3,
    ACT_READ_BIT   = 3'd4
  } action_t;

  // status codes
  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    action_t    action;
    logic [7:0] value;
    logic [2:0] bit_offset;
    logic       mapped;   // byte lives in a pool slot
    logic       err;      // modify dropped, pool exhausted
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

@@ design/tlsbs_ram.sv @@
// ----------------------------------------------------------------------------
// tlsbs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tlsbs_ram #(
  parameter int     WIDTH = 8,
  parameter longint DEPTH = 256,
  localparam int    AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tlsbs_queue.sv @@
// ----------------------------------------------------------------------------
// tlsbs_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tlsbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlsbs_pkg::QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign dout  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ design/tlsbs_front.sv @@
// ----------------------------------------------------------------------------
// tlsbs_front
// Accepts items, looks up the page table, allocates pool slots for modifies
// of unmapped pages and pushes a classified item into the queue.
// ----------------------------------------------------------------------------
module tlsbs_front #(
  parameter int  POOL_PAGES         = tlsbs_pkg::POOL_PAGES_DEF,
  parameter int  PAGE_OFFSET_BITS   = tlsbs_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int  PAGE_TABLE_ENTRIES = tlsbs_pkg::PAGE_TABLE_ENTRIES_DEF,
  parameter int  CLR_W              = 20,
  localparam int PT_AW      = $clog2(PAGE_TABLE_ENTRIES),
  localparam int ENT_W      = $clog2(POOL_PAGES + 1),
  localparam int SLOT_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1,
  localparam longint POOL_DEPTH = longint'(POOL_PAGES) << PAGE_OFFSET_BITS,
  localparam int POOL_AW    = $clog2(POOL_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clearing,
  input  logic [CLR_W-1:0]     clr_idx,
  input  logic                 start,
  input  logic [2:0]           action,
  input  logic [31:0]          address,
  input  logic [7:0]           value,
  input  logic [2:0]           bit_offset,
  output logic                 busy,
  input  logic                 q_full,
  output logic                 push,
  output tlsbs_pkg::cmd_t      push_cmd,
  output logic [POOL_AW-1:0]   push_addr
);

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_LOOKUP = 2'b10
  } front_state_t;

  front_state_t                state;
  logic [ENT_W-1:0]            pages_used;
  logic [2:0]                  act_q;
  logic [PT_AW-1:0]            page_q;
  logic [PAGE_OFFSET_BITS-1:0] off_q;
  logic [7:0]                  value_q;
  logic [2:0]                  bit_q;

  logic                        accept;
  logic [ENT_W-1:0]            ent;
  logic                        mapped;
  logic                        is_mod;
  logic                        room;
  logic                        alloc;
  logic [SLOT_W-1:0]           slot;
  logic                        pt_we;
  logic [PT_AW-1:0]            pt_waddr;
  logic [ENT_W-1:0]            pt_wdata;

  assign busy   = clearing || (state != F_IDLE) || q_full;
  assign accept = start && !busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      pages_used <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_LOOKUP;
          end
        end
        F_LOOKUP: begin
          state <= F_IDLE;
          if (alloc) begin
            pages_used <= ENT_W'(pages_used + 1'b1);
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= action;
      page_q  <= address[PAGE_OFFSET_BITS +: PT_AW];
      off_q   <= address[PAGE_OFFSET_BITS-1:0];
      value_q <= value;
      bit_q   <= bit_offset;
    end
  end

  // classify against the page table entry
  always_comb begin
    case (tlsbs_pkg::action_t'(act_q))
      tlsbs_pkg::ACT_WRITE_BYTE, tlsbs_pkg::ACT_SET_BIT,
      tlsbs_pkg::ACT_CLEAR_BIT: is_mod = 1'b1;
      default:                  is_mod = 1'b0;
    endcase
  end

  assign mapped = (ent != '0) && (ent <= ENT_W'(POOL_PAGES));
  assign room   = pages_used < ENT_W'(POOL_PAGES);
  assign alloc  = (state == F_LOOKUP) && is_mod && !mapped && room;
  assign slot   = mapped ? SLOT_W'(ent - 1'b1) : SLOT_W'(pages_used);

  // queue push
  assign push                = (state == F_LOOKUP);
  assign push_cmd.action     = tlsbs_pkg::action_t'(act_q);
  assign push_cmd.value      = value_q;
  assign push_cmd.bit_offset = bit_q;
  assign push_cmd.mapped     = mapped || (is_mod && room);
  assign push_cmd.err        = is_mod && !mapped && !room;
  assign push_addr           = POOL_AW'({slot, off_q});

  // page table write: clearing pass or new mapping
  always_comb begin
    if (clearing) begin
      pt_we    = longint'(clr_idx) < longint'(PAGE_TABLE_ENTRIES);
      pt_waddr = PT_AW'(clr_idx);
      pt_wdata = '0;
    end else begin
      pt_we    = alloc;
      pt_waddr = page_q;
      pt_wdata = ENT_W'(pages_used + 1'b1);
    end
  end

  tlsbs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (longint'(PAGE_TABLE_ENTRIES))
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (address[PAGE_OFFSET_BITS +: PT_AW]),
    .rdata (ent)
  );

  // assertions
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("front pushed into a full queue");
  a_alloc_bounded: assert property (@(posedge clk) disable iff (rst)
    alloc |-> pages_used < ENT_W'(POOL_PAGES))
    else $error("slot handed out past the pool");
  a_err_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.err) |=> $stable(pages_used))
    else $error("dropped modify changed the slot count");

endmodule

@@ design/tlsbs_back.sv @@
// ----------------------------------------------------------------------------
// tlsbs_back
// Pops classified items, reads the pool byte, applies the modify and
// emits one result per item.
// ----------------------------------------------------------------------------
module tlsbs_back #(
  parameter int  POOL_PAGES       = tlsbs_pkg::POOL_PAGES_DEF,
  parameter int  PAGE_OFFSET_BITS = tlsbs_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int  CLR_W            = 20,
  localparam longint POOL_DEPTH   = longint'(POOL_PAGES) << PAGE_OFFSET_BITS,
  localparam int POOL_AW          = $clog2(POOL_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clearing,
  input  logic [CLR_W-1:0]   clr_idx,
  input  logic               q_empty,
  input  tlsbs_pkg::cmd_t    q_cmd,
  input  logic [POOL_AW-1:0] q_addr,
  output logic               pop,
  output logic               done,
  output logic [7:0]         data,
  output logic               status
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } back_state_t;

  back_state_t          state;
  tlsbs_pkg::cmd_t      cmd_q;
  logic [POOL_AW-1:0]   addr_q;

  logic [7:0]           rd_byte;
  logic [7:0]           cur;
  logic [7:0]           mask;
  logic [7:0]           new_byte;
  logic                 wr;
  logic [7:0]           res_data;
  logic                 pool_we;
  logic [POOL_AW-1:0]   pool_waddr;
  logic [7:0]           pool_wdata;

  assign pop = (state == B_IDLE) && !q_empty && !clearing;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_EXEC;
          end
        end
        B_EXEC:  state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q  <= q_cmd;
      addr_q <= q_addr;
    end
  end

  // execute: unmapped bytes read as zero
  assign cur  = cmd_q.mapped ? rd_byte : 8'h00;
  assign mask = 8'h01 << cmd_q.bit_offset;

  always_comb begin
    res_data = 8'h00;
    new_byte = cur;
    wr       = 1'b0;
    case (cmd_q.action)
      tlsbs_pkg::ACT_READ_BYTE: res_data = cur;
      tlsbs_pkg::ACT_READ_BIT:  res_data = {7'b0, cur[cmd_q.bit_offset]};
      tlsbs_pkg::ACT_WRITE_BYTE: begin
        new_byte = cmd_q.value;
        wr       = cmd_q.mapped;
      end
      tlsbs_pkg::ACT_SET_BIT: begin
        new_byte = cur | mask;
        wr       = cmd_q.mapped;
      end
      tlsbs_pkg::ACT_CLEAR_BIT: begin
        new_byte = cur & ~mask;
        wr       = cmd_q.mapped;
      end
      default: ;
    endcase
  end

  // pool write: clearing pass or modify
  always_comb begin
    if (clearing) begin
      pool_we    = longint'(clr_idx) < POOL_DEPTH;
      pool_waddr = POOL_AW'(clr_idx);
      pool_wdata = 8'h00;
    end else begin
      pool_we    = (state == B_EXEC) && wr;
      pool_waddr = addr_q;
      pool_wdata = new_byte;
    end
  end

  tlsbs_ram #(
    .WIDTH (8),
    .DEPTH (POOL_DEPTH)
  ) u_page_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (q_addr),
    .rdata (rd_byte)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == B_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      data   <= res_data;
      status <= cmd_q.err ? tlsbs_pkg::STATUS_POOL_FULL : tlsbs_pkg::STATUS_DONE;
    end
  end

  // assertions
  a_no_write_on_err: assert property (@(posedge clk) disable iff (rst)
    (state == B_EXEC && cmd_q.err) |-> !pool_we)
    else $error("pool written for a dropped modify");
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == B_EXEC) |=> (state == B_IDLE) && done)
    else $error("execute did not produce a result");

endmodule

@@ design/two_level_shadow_byte_store.sv @@
// ----------------------------------------------------------------------------
// two_level_shadow_byte_store
// Byte-per-byte metadata store over a 32-bit address space: a page table maps
// each page to a shared zero page or to a slot of a pool of real pages.
//
// Usage: drive action, address, value and bit_offset and raise start; the
// item is taken at the clock edge where start is high and busy is low. Each
// item gives exactly one result on data and status, marked by done for one
// cycle; the receiver cannot hold results off and needs no handshake.
// An accepted item passes the front lookup state, the queue and the back
// execute state; data, status and done are registered behind it. The front
// takes no new item during its page table lookup and mapping update or while
// the queue is full; the back pops none during its pool read and read-modify-write.
// Reset: rst is synchronous. After it a clearing pass zeroes the page table
// and the pool, one entry per cycle, stepping an index over every value of
// the wider of the table and pool addresses; busy stays high through it.
// Page table entries must be a power of two.
// ----------------------------------------------------------------------------
module two_level_shadow_byte_store #(
  parameter int POOL_PAGES         = tlsbs_pkg::POOL_PAGES_DEF,
  parameter int PAGE_OFFSET_BITS   = tlsbs_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int PAGE_TABLE_ENTRIES = tlsbs_pkg::PAGE_TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  action,
  input  logic [31:0] address,
  input  logic [7:0]  value,
  input  logic [2:0]  bit_offset,
  output logic        busy,
  output logic        done,
  output logic [7:0]  data,
  output logic        status
);

  localparam int     PT_AW      = $clog2(PAGE_TABLE_ENTRIES);
  localparam longint POOL_DEPTH = longint'(POOL_PAGES) << PAGE_OFFSET_BITS;
  localparam int     POOL_AW    = $clog2(POOL_DEPTH);
  localparam int     CLR_W      = (PT_AW > POOL_AW) ? PT_AW : POOL_AW;

  logic                  clearing;
  logic [CLR_W-1:0]      clr_idx;

  logic                  push;
  tlsbs_pkg::cmd_t       push_cmd;
  logic [POOL_AW-1:0]    push_addr;
  logic                  pop;
  logic                  q_empty;
  logic                  q_full;
  logic [tlsbs_pkg::CMD_W+POOL_AW-1:0] q_dout;
  tlsbs_pkg::cmd_t       q_cmd;
  logic [POOL_AW-1:0]    q_addr;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= CLR_W'(clr_idx + 1'b1);
      if (&clr_idx) begin
        clearing <= 1'b0;
      end
    end
  end

  tlsbs_front #(
    .POOL_PAGES         (POOL_PAGES),
    .PAGE_OFFSET_BITS   (PAGE_OFFSET_BITS),
    .PAGE_TABLE_ENTRIES (PAGE_TABLE_ENTRIES),
    .CLR_W              (CLR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .clr_idx    (clr_idx),
    .start      (start),
    .action     (action),
    .address    (address),
    .value      (value),
    .bit_offset (bit_offset),
    .busy       (busy),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr)
  );

  tlsbs_queue #(
    .WIDTH (tlsbs_pkg::CMD_W + POOL_AW),
    .DEPTH (tlsbs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_cmd, push_addr}),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  assign q_cmd  = tlsbs_pkg::cmd_t'(q_dout[POOL_AW +: tlsbs_pkg::CMD_W]);
  assign q_addr = q_dout[POOL_AW-1:0];

  tlsbs_back #(
    .POOL_PAGES       (POOL_PAGES),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .CLR_W            (CLR_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .clr_idx  (clr_idx),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd),
    .q_addr   (q_addr),
    .pop      (pop),
    .done     (done),
    .data     (data),
    .status   (status)
  );

  // assertions
  a_busy_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy)
    else $error("item could be taken during the clearing pass");
  a_err_data_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == tlsbs_pkg::STATUS_POOL_FULL) |-> data == 8'h00)
    else $error("dropped modify returned nonzero data");
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results closer than two cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front took a second item during lookup");

endmodule

@@ dv/shadow_store_checker.sv @@
// ----------------------------------------------------------------------------
// shadow_store_checker
// Watches the command and result channels of the shadow byte store and keeps
// its own image of the page map and the slot pool. Each accepted item is run
// through that image to give the expected data and status. Each done strobe
// is compared against the oldest expected result.
// ----------------------------------------------------------------------------
module shadow_store_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  action,
  input  logic [31:0] address,
  input  logic [7:0]  value,
  input  logic [2:0]  bit_offset,
  input  logic        done,
  input  logic [7:0]  data,
  input  logic        status,
  output int          mismatches,
  output int          items_in_flight,
  output int          results_checked,
  output int          pool_full_drops,
  output int          slots_taken
);

  localparam int OFFSET_BITS   = tlsbs_pkg::PAGE_OFFSET_BITS_DEF;
  localparam int TABLE_ENTRIES = tlsbs_pkg::PAGE_TABLE_ENTRIES_DEF;
  localparam int SLOT_COUNT    = tlsbs_pkg::POOL_PAGES_DEF;
  localparam int PAGE_BYTES    = 1 << OFFSET_BITS;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
  } outcome_t;

  // page map: 0 is the zero page, k+1 is pool slot k
  logic [4:0]  page_map [TABLE_ENTRIES];
  // written pool bytes only, keyed by slot * page size + offset
  logic [7:0]  pool_image [int unsigned];
  int unsigned next_free_slot;
  outcome_t    awaited_results [$];
  outcome_t    oldest;

  // one line per mismatch, counted
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
  endtask

  // run one item through the page map and pool image
  function automatic outcome_t apply_item_to_store(
    input logic [2:0]  act,
    input logic [31:0] addr,
    input logic [7:0]  val,
    input logic [2:0]  bit_pos
  );
    int unsigned page;
    int unsigned offset;
    int unsigned key;
    logic [4:0]  entry;
    logic [7:0]  stored;
    outcome_t    res;
    page   = (addr >> OFFSET_BITS) % TABLE_ENTRIES;
    offset = addr & (PAGE_BYTES - 1);
    entry  = page_map[page];
    key    = 0;
    stored = 8'h00;
    res    = '{data: 8'h00, status: tlsbs_pkg::STATUS_DONE};
    if (entry != 0) begin
      key = (entry - 1) * PAGE_BYTES + offset;
      if (pool_image.exists(key))
        stored = pool_image[key];
    end
    case (act)
      tlsbs_pkg::ACT_READ_BYTE: res.data = stored;
      tlsbs_pkg::ACT_READ_BIT:  res.data = {7'b0, stored[bit_pos]};
      tlsbs_pkg::ACT_WRITE_BYTE, tlsbs_pkg::ACT_SET_BIT, tlsbs_pkg::ACT_CLEAR_BIT: begin
        if (entry == 0 && next_free_slot >= SLOT_COUNT) begin
          // pool exhausted, modify dropped
          res.status = tlsbs_pkg::STATUS_POOL_FULL;
        end else begin
          // first modify of a page takes the next slot, which starts zero
          if (entry == 0) begin
            next_free_slot++;
            entry          = 5'(next_free_slot);
            page_map[page] = entry;
            key            = (entry - 1) * PAGE_BYTES + offset;
          end
          if (act == tlsbs_pkg::ACT_WRITE_BYTE)
            stored = val;
          else if (act == tlsbs_pkg::ACT_SET_BIT)
            stored[bit_pos] = 1'b1;
          else
            stored[bit_pos] = 1'b0;
          pool_image[key] = stored;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // capture accepted items, check strobed results
  always @(posedge clk) begin
    if (rst) begin
      foreach (page_map[i]) page_map[i] = '0;
      pool_image.delete();
      awaited_results.delete();
      next_free_slot  = 0;
      mismatches      = 0;
      results_checked = 0;
      pool_full_drops = 0;
    end else begin
      if (start === 1'b1 && busy === 1'b0)
        awaited_results.push_back(apply_item_to_store(action, address, value, bit_offset));
      if (done === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting: data 0x%02h status %0d",
                                    data, status));
        end else begin
          oldest = awaited_results.pop_front();
          results_checked++;
          if (oldest.status == tlsbs_pkg::STATUS_POOL_FULL)
            pool_full_drops++;
          if (data !== oldest.data)
            report_mismatch($sformatf("result %0d data: expected 0x%02h got 0x%02h",
                                      results_checked, oldest.data, data));
          if (status !== oldest.status)
            report_mismatch($sformatf("result %0d status: expected %0d got %0d",
                                      results_checked, oldest.status, status));
        end
      end
    end
    items_in_flight = awaited_results.size();
    slots_taken     = next_free_slot;
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the shadow byte store. After the clearing pass a
// short directed run covers field extremes, every action, copy-on-write
// allocation, bit reads on empty pages and unused action codes. A random run
// then hammers a small set of hot pages and offsets, with address repeats for
// back-to-back hazards, enough pages to exhaust the pool, and some noise,
// across phases of sender idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int PHASE_COUNT    = 4;
  localparam int HOT_PAGE_COUNT = 20;
  localparam int HOT_OFF_COUNT  = 6;

  // action codes with no meaning
  localparam logic [2:0] FIRST_UNUSED_ACT = 3'd5;
  localparam logic [2:0] LAST_UNUSED_ACT  = 3'd7;

  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [2:0]  action     = tlsbs_pkg::ACT_READ_BYTE;
  logic [31:0] address    = '0;
  logic [7:0]  value      = '0;
  logic [2:0]  bit_offset = '0;
  logic        busy;
  logic        done;
  logic [7:0]  data;
  logic        status;

  int          mismatches;
  int          items_in_flight;
  int          results_checked;
  int          pool_full_drops;
  int          slots_taken;
  int          cycle_count = 0;

  logic [15:0] hot_pages [HOT_PAGE_COUNT];
  logic [15:0] hot_offsets [HOT_OFF_COUNT];
  logic [31:0] last_address = '0;
  int          idle_pct;
  bit          burst;

  two_level_shadow_byte_store uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .address    (address),
    .value      (value),
    .bit_offset (bit_offset),
    .busy       (busy),
    .done       (done),
    .data       (data),
    .status     (status)
  );

  shadow_store_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .address         (address),
    .value           (value),
    .bit_offset      (bit_offset),
    .done            (done),
    .data            (data),
    .status          (status),
    .mismatches      (mismatches),
    .items_in_flight (items_in_flight),
    .results_checked (results_checked),
    .pool_full_drops (pool_full_drops),
    .slots_taken     (slots_taken)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still in flight",
               cycle_count, items_in_flight);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_command(
    input logic [2:0]  act,
    input logic [31:0] addr,
    input logic [7:0]  val,
    input logic [2:0]  bit_pos
  );
    start      <= 1'b1;
    action     <= act;
    address    <= addr;
    value      <= val;
    bit_offset <= bit_pos;
    last_address = addr;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // drop start for a random idle gap outside bursts, per the current idle rate
  task automatic maybe_idle();
    if (idle_pct != 0 && !burst && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // mostly hot pages and offsets with repeats, some noise
  task automatic issue_random_item();
    int          pick;
    logic [2:0]  act;
    logic [15:0] page;
    logic [15:0] offset;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 25)      act = tlsbs_pkg::ACT_READ_BYTE;
    else if (pick < 45) act = tlsbs_pkg::ACT_WRITE_BYTE;
    else if (pick < 60) act = tlsbs_pkg::ACT_SET_BIT;
    else if (pick < 75) act = tlsbs_pkg::ACT_CLEAR_BIT;
    else if (pick < 95) act = tlsbs_pkg::ACT_READ_BIT;
    else                act = 3'($urandom_range(FIRST_UNUSED_ACT, LAST_UNUSED_ACT));
    page = hot_pages[$urandom_range(0, HOT_PAGE_COUNT - 1)];
    if ($urandom_range(0, 99) < 70)
      offset = hot_offsets[$urandom_range(0, HOT_OFF_COUNT - 1)];
    else
      offset = 16'($urandom_range(0, 16'hffff));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // noise: any code, reads land anywhere in the address space
      act = 3'($urandom_range(0, 7));
      if (act == tlsbs_pkg::ACT_WRITE_BYTE || act == tlsbs_pkg::ACT_SET_BIT ||
          act == tlsbs_pkg::ACT_CLEAR_BIT)
        addr = {page, offset};
      else
        addr = $urandom();
    end else if (pick < 40) begin
      // same byte again, back to back when not idling
      addr = last_address;
    end else begin
      addr = {page, offset};
    end
    send_command(act, addr, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  // stimulus and verdict
  initial begin
    idle_pct = 0;
    burst    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty reads, allocation, read-modify-write, unused codes
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h0000_0000, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BIT,   32'hffff_ffff, 8'hff, 3'd7);
    send_command(tlsbs_pkg::ACT_WRITE_BYTE, 32'hffff_ffff, 8'hff, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'hffff_ffff, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BIT,   32'hffff_ffff, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_CLEAR_BIT,  32'hffff_ffff, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'hffff_ffff, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BIT,   32'hffff_ffff, 8'h00, 3'd7);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'hffff_0000, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_SET_BIT,    32'h0000_0000, 8'h00, 3'd7);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h0000_0000, 8'h00, 3'd0);
    // a zero write still takes a slot
    send_command(tlsbs_pkg::ACT_WRITE_BYTE, 32'h8001_1234, 8'h00, 3'd0);
    // bit read of an empty page must not take a slot
    send_command(tlsbs_pkg::ACT_READ_BIT,   32'h0001_1234, 8'hff, 3'd3);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h0001_1234, 8'h00, 3'd0);
    send_command(FIRST_UNUSED_ACT,          32'hffff_ffff, 8'h55, 3'd1);
    send_command(3'(FIRST_UNUSED_ACT + 1),  32'h0002_0000, 8'haa, 3'd2);
    send_command(LAST_UNUSED_ACT,           32'h0002_0000, 8'hff, 3'd7);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h0002_0000, 8'h00, 3'd0);
    // clear on an empty page allocates and leaves zero
    send_command(tlsbs_pkg::ACT_CLEAR_BIT,  32'h7fff_0000, 8'h00, 3'd5);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h7fff_0000, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_WRITE_BYTE, 32'h8001_1234, 8'ha5, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BYTE,  32'h8001_1234, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_SET_BIT,    32'h0000_ffff, 8'h00, 3'd0);
    send_command(tlsbs_pkg::ACT_READ_BIT,   32'h0000_ffff, 8'h00, 3'd0);

    // hot set: directed pages plus fresh ones, more than the pool holds
    hot_pages[0] = 16'hffff;
    hot_pages[1] = 16'h0000;
    hot_pages[2] = 16'h8001;
    hot_pages[3] = 16'h7fff;
    for (int i = 4; i < HOT_PAGE_COUNT; i++)
      hot_pages[i] = 16'($urandom_range(0, 16'hffff));
    hot_offsets[0] = 16'h0000;
    hot_offsets[1] = 16'hffff;
    for (int i = 2; i < HOT_OFF_COUNT; i++)
      hot_offsets[i] = 16'($urandom_range(0, 16'hffff));

    // random run over idle phases: none, heavy, none, light
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        1:       idle_pct = 48;
        3:       idle_pct = 16;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
        if (n % 25 == 0)
          burst = ($urandom_range(0, 99) < 30);
        maybe_idle();
        issue_random_item();
      end
    end
    start <= 1'b0;

    // drain
    while (items_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results over %0d cycles, %0d random items in %0d idle phases",
             results_checked, cycle_count, RANDOM_ITEMS, PHASE_COUNT);
    $display("pool slots taken %0d, modifies dropped on a full pool %0d",
             slots_taken, pool_full_drops);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
